### src/lcdnw_pkg.sv
`timescale 1ns / 1ps
package lcdnw_pkg;

  localparam int NUM_W          = 31;
  localparam int BYTE_W         = 8;
  localparam int NIB_W          = 4;
  localparam int ACT_W          = 2;
  localparam int CNT_W          = $clog2(NUM_W);
  localparam int INIT_BYTES     = 4;
  // A 31-bit number never has more than ten decimal digits.
  localparam int BCD_DIGITS_CAP = 10;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] INIT_CMD0  = 8'h33;
  localparam logic [BYTE_W-1:0] INIT_CMD1  = 8'h32;
  localparam logic [BYTE_W-1:0] INIT_CMD2  = 8'h0C;
  localparam logic [BYTE_W-1:0] INIT_CMD3  = 8'h01;

  typedef enum logic [ACT_W-1:0] {
    ACT_CMD    = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_NUMBER = 2'd2,
    ACT_INIT   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SEND_HI,
    ST_SEND_LO
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic adv;
    logic emit;
    logic half;
  } lcdnw_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic skip_more;
    logic last_byte;
    logic out_free;
  } lcdnw_sts_t;

  // The init counter runs down from four, so its low two bits pick the command.
  function automatic logic [BYTE_W-1:0] init_byte(input logic [1:0] sel);
    logic [BYTE_W-1:0] b;
    unique case (sel)
      2'd0: b = INIT_CMD0;
      2'd3: b = INIT_CMD1;
      2'd2: b = INIT_CMD2;
      2'd1: b = INIT_CMD3;
      default: b = INIT_CMD0;
    endcase
    return b;
  endfunction

endpackage

### src/lcdnw_if.sv
`timescale 1ns / 1ps
interface lcdnw_in_if;
  logic                            valid;
  logic                            ready;
  logic [lcdnw_pkg::ACT_W-1:0]     action;
  logic [lcdnw_pkg::BYTE_W-1:0]    byte_value;
  logic [lcdnw_pkg::NUM_W-1:0]     number;

  modport source(output valid, action, byte_value, number, input ready);
  modport sink(input valid, action, byte_value, number, output ready);
endinterface

interface lcdnw_out_if;
  logic                          valid;
  logic                          ready;
  logic                          register_select;
  logic [lcdnw_pkg::NIB_W-1:0]   nibble;
  logic                          last;

  modport source(output valid, register_select, nibble, last, input ready);
  modport sink(input valid, register_select, nibble, last, output ready);
endinterface

### src/char_lcd_nibble_writer_core.sv
`timescale 1ns / 1ps
// Command and data requests: accepted, then two nibbles, each sent when the output is free.
// Init requests: eight nibbles, one every cycle the output register is free.
// Number requests: a conversion phase (one input bit per cycle through the BCD
// converter), a skip state that finds the first digit by dropping suppressed
// leading zeros, then two nibbles per digit, up to ten digits.
// One request is worked at a time; the output register frees the bus side from stalls.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
module char_lcd_nibble_writer_core #(
  parameter int MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  lcdnw_in_if.sink    in_ch,
  lcdnw_out_if.source out_ch
);
  import lcdnw_pkg::*;

  lcdnw_cmd_t cmd;
  lcdnw_sts_t sts;
  logic       in_ready;

  lcdnw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  lcdnw_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_action           (in_ch.action),
    .in_byte_value       (in_ch.byte_value),
    .in_number           (in_ch.number),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_register_select (out_ch.register_select),
    .out_nibble          (out_ch.nibble),
    .out_last            (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  // A request is worked alone, so ready drops right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a request is still in progress");

  // A nibble is only loaded when the output register is empty or being drained.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("nibble emitted over a held result");

  // The conversion phase and the nibble transfers never overlap.
  a_no_emit_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.conv_step |-> !cmd.emit && !cmd.adv)
    else $error("transfer issued during decimal conversion");

endmodule

### src/lcdnw_ctrl.sv
`timescale 1ns / 1ps
module lcdnw_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [lcdnw_pkg::ACT_W-1:0]      in_action,
  input  lcdnw_pkg::lcdnw_sts_t            sts,
  output logic                             in_ready,
  output lcdnw_pkg::lcdnw_cmd_t            cmd
);
  import lcdnw_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (action_t'(in_action) == ACT_NUMBER) ? ST_CONVERT : ST_SEND_HI;
        end
      end
      ST_CONVERT: begin
        if (sts.conv_done) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!sts.skip_more) begin
          state_nxt = ST_SEND_HI;
        end
      end
      ST_SEND_HI: begin
        if (sts.out_free) begin
          state_nxt = ST_SEND_LO;
        end
      end
      ST_SEND_LO: begin
        if (sts.out_free) begin
          state_nxt = sts.last_byte ? ST_IDLE : ST_SEND_HI;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.load      = (state_r == ST_IDLE) && in_valid;
    cmd.conv_step = (state_r == ST_CONVERT);
    cmd.adv       = ((state_r == ST_SKIP) && sts.skip_more) ||
                    ((state_r == ST_SEND_LO) && sts.out_free && !sts.last_byte);
    cmd.emit      = ((state_r == ST_SEND_HI) || (state_r == ST_SEND_LO)) && sts.out_free;
    cmd.half      = (state_r == ST_SEND_LO);
  end

endmodule

### src/lcdnw_dp.sv
`timescale 1ns / 1ps
module lcdnw_dp #(
  parameter int MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lcdnw_pkg::ACT_W-1:0]      in_action,
  input  logic [lcdnw_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic [lcdnw_pkg::NUM_W-1:0]      in_number,
  input  lcdnw_pkg::lcdnw_cmd_t            cmd,
  output lcdnw_pkg::lcdnw_sts_t            sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_register_select,
  output logic [lcdnw_pkg::NIB_W-1:0]      out_nibble,
  output logic                             out_last
);
  import lcdnw_pkg::*;

  localparam int DIG     = (MAX_DIGITS < BCD_DIGITS_CAP) ? MAX_DIGITS : BCD_DIGITS_CAP;
  localparam int BCD_W   = NIB_W * DIG;
  localparam int REM_MAX = (DIG > INIT_BYTES) ? DIG : INIT_BYTES;
  localparam int REM_W   = $clog2(REM_MAX + 1);

  action_t             action_r;
  logic                rs_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [NUM_W-1:0]    bin_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [BCD_W-1:0]    bcd_adj;
  logic [CNT_W-1:0]    cnt_r;
  logic [REM_W-1:0]    rem_r;
  logic                ovf_r;
  logic [NIB_W-1:0]    top_digit;
  logic [BYTE_W-1:0]   cur_byte;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_rs_r;
  logic [NIB_W-1:0]    out_nibble_r;
  logic                out_last_r;

  // Shift-and-add-3: digits of five or more are corrected before each doubling.
  // Carries out of the top digit are dropped, which keeps the lowest digits only.
  // Any dropped carry marks a number too long for the digit count; all of its
  // kept digits are sent, leading zeros included.
  always_comb begin
    for (int i = 0; i < DIG; i++) begin
      bcd_adj[NIB_W*i +: NIB_W] = (bcd_r[NIB_W*i +: NIB_W] >= 4'd5) ?
                                  bcd_r[NIB_W*i +: NIB_W] + 4'd3 :
                                  bcd_r[NIB_W*i +: NIB_W];
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: NIB_W];

  always_comb begin
    unique case (action_r)
      ACT_CMD, ACT_DATA: cur_byte = byte_r;
      ACT_NUMBER:        cur_byte = ASCII_ZERO | {4'h0, top_digit};
      ACT_INIT:          cur_byte = init_byte(rem_r[1:0]);
      default:           cur_byte = byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action_t'(in_action);
      rs_r     <= (action_t'(in_action) == ACT_DATA) || (action_t'(in_action) == ACT_NUMBER);
      byte_r   <= in_byte_value;
      bin_r    <= in_number;
      bcd_r    <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      unique case (action_t'(in_action))
        ACT_CMD, ACT_DATA: rem_r <= REM_W'(1);
        ACT_NUMBER:        rem_r <= REM_W'(DIG);
        ACT_INIT:          rem_r <= REM_W'(INIT_BYTES);
        default:           rem_r <= REM_W'(1);
      endcase
    end else if (cmd.conv_step) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[NUM_W-1]};
      bin_r <= {bin_r[NUM_W-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
      ovf_r <= ovf_r | bcd_adj[BCD_W-1];
    end else if (cmd.adv) begin
      bcd_r <= bcd_r << NIB_W;
      rem_r <= rem_r - REM_W'(1);
    end
  end

  always_comb begin
    sts.conv_done = (cnt_r == CNT_W'(NUM_W - 1));
    sts.skip_more = !ovf_r && (top_digit == '0) && (rem_r != REM_W'(1));
    sts.last_byte = (rem_r == REM_W'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rs_r     <= rs_r;
      out_nibble_r <= cmd.half ? cur_byte[NIB_W-1:0] : cur_byte[BYTE_W-1:NIB_W];
      out_last_r   <= cmd.half && sts.last_byte;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = out_rs_r;
  assign out_nibble          = out_nibble_r;
  assign out_last            = out_last_r;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import lcdnw_pkg::*;

  localparam int DIGIT_LIMIT = MAX_DIGITS_DEF;
  localparam int RANDOM_REQUESTS = 280;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic             rs;
    logic [NIB_W-1:0] nib;
    logic             last;
  } lcd_nibble_t;

  class lcd_bus_scoreboard;
    lcd_nibble_t awaited[$];
    int errors;
    int nibbles_seen;
    int requests_seen;
    int per_action[4];

    function void push_byte(logic rs, logic [BYTE_W-1:0] b, logic fin);
      awaited.push_back('{rs: rs, nib: b[7:4], last: 1'b0});
      awaited.push_back('{rs: rs, nib: b[3:0], last: fin});
    endfunction

    // Expands one accepted request into the nibble stream the bus should carry.
    function void note_request(action_t act, logic [BYTE_W-1:0] b, logic [NUM_W-1:0] num);
      logic [3:0] digits[20];
      int nd;
      int lim;
      logic [NUM_W-1:0] rest;
      requests_seen++;
      per_action[act]++;
      case (act)
        ACT_CMD:  push_byte(1'b0, b, 1'b1);
        ACT_DATA: push_byte(1'b1, b, 1'b1);
        ACT_NUMBER: begin
          lim = DIGIT_LIMIT;
          if (lim > 20) lim = 20;
          if (lim < 1) lim = 1;
          nd = 0;
          rest = num;
          // Zero still yields one digit; overlong values keep only their low digits.
          do begin
            digits[nd] = 4'(rest % 10);
            rest = NUM_W'(rest / 10);
            nd++;
          end while (rest != 0 && nd < lim);
          for (int k = nd - 1; k >= 0; k--)
            push_byte(1'b1, ASCII_ZERO + BYTE_W'(digits[k]), k == 0);
        end
        default: begin
          push_byte(1'b0, INIT_CMD0, 1'b0);
          push_byte(1'b0, INIT_CMD1, 1'b0);
          push_byte(1'b0, INIT_CMD2, 1'b0);
          push_byte(1'b0, INIT_CMD3, 1'b1);
        end
      endcase
    endfunction

    function void check_nibble(logic rs, logic [NIB_W-1:0] nib, logic last);
      lcd_nibble_t want;
      nibbles_seen++;
      if (awaited.size() == 0) begin
        $error("unexpected nibble: register_select=%0b nibble=%h last=%0b", rs, nib, last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (rs !== want.rs) begin
        $error("register_select: expected %0b, got %0b", want.rs, rs);
        errors++;
      end
      if (nib !== want.nib) begin
        $error("nibble: expected %h, got %h", want.nib, nib);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycles;
  lcd_bus_scoreboard sb;

  lcdnw_in_if  in_ch();
  lcdnw_out_if out_ch();

  char_lcd_nibble_writer_core #(.MAX_DIGITS(DIGIT_LIMIT)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_nibble(out_ch.register_select, out_ch.nibble, out_ch.last);
  end

  // The display side stalls in bursts until the final stretch of the run.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(action_t act, logic [BYTE_W-1:0] b, logic [NUM_W-1:0] num);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.byte_value <= b;
    in_ch.number     <= num;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(act, b, num);
  endtask

  task automatic drain_display();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic logic [NUM_W-1:0] random_number();
    longint span;
    int k;
    k = $urandom_range(1, 11);
    if (k == 11) return NUM_W'($urandom);
    span = 1;
    repeat (k) span = span * 10;
    return NUM_W'(longint'($urandom) % span);
  endfunction

  initial begin
    int pick;
    action_t act;
    sb = new();
    calm = 1'b0;
    cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_CMD;
    in_ch.byte_value = '0;
    in_ch.number = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Byte extremes, every action, zero, one- and ten-digit numbers, ignored fields.
    send_request(ACT_CMD, 8'h00, 31'h7FFF_FFFF);
    send_request(ACT_CMD, 8'hFF, '0);
    send_request(ACT_CMD, 8'hA5, NUM_W'($urandom));
    send_request(ACT_DATA, 8'h00, 31'h5555_5555);
    send_request(ACT_DATA, 8'hFF, '0);
    send_request(ACT_DATA, 8'h5A, NUM_W'($urandom));
    send_request(ACT_NUMBER, 8'hFF, 31'd0);
    send_request(ACT_NUMBER, 8'h00, 31'd9);
    send_request(ACT_NUMBER, 8'h3C, 31'd10);
    send_request(ACT_NUMBER, 8'h00, 31'd2147483647);
    send_request(ACT_NUMBER, 8'h00, 31'd1000000000);
    send_request(ACT_NUMBER, 8'h81, 31'd1234567890);
    send_request(ACT_NUMBER, 8'h00, 31'd999999999);
    send_request(ACT_INIT, 8'h00, '0);
    send_request(ACT_INIT, 8'hFF, 31'h7FFF_FFFF);
    send_request(ACT_INIT, 8'h3C, NUM_W'($urandom));
    send_request(ACT_CMD, 8'h01, '0);
    drain_display();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) drain_display();
      if (i == RANDOM_REQUESTS - 40) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) act = ACT_NUMBER;
      else if (pick < 60) act = ACT_CMD;
      else if (pick < 85) act = ACT_DATA;
      else act = ACT_INIT;
      send_request(act, BYTE_W'($urandom), $urandom_range(0, 19) == 0 ? '0 : random_number());
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected nibbles never arrived", sb.pending());
      sb.errors++;
    end

    $display("Sent %0d requests: %0d commands, %0d data bytes, %0d numbers, %0d init runs.",
             sb.requests_seen, sb.per_action[ACT_CMD], sb.per_action[ACT_DATA],
             sb.per_action[ACT_NUMBER], sb.per_action[ACT_INIT]);
    $display("Checked %0d nibbles on the LCD bus with random stalls on both sides.",
             sb.nibbles_seen);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
src/lcdnw_pkg.sv
src/lcdnw_if.sv
src/lcdnw_ctrl.sv
src/lcdnw_dp.sv
src/char_lcd_nibble_writer_core.sv
dv/tb.sv
